>>> src/assert_macros.svh
// Assertion macros shared by the ray box slope test modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the condition holds in the same cycle as the trigger.
`define RBST_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("rbst assertion failed");

// Checks that the condition holds in the cycle after the trigger.
`define RBST_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("rbst assertion failed");

`endif

>>> src/rbst_pkg.sv
// Package with the shared types, codes and pair tables of the ray box slope test.
package rbst_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_LD_MUL,
    ST_LD_SUB,
    ST_TS_MUL,
    ST_TS_CHK,
    ST_DONE
  } state_t;

  localparam logic [1:0] SGN_M = 2'd0;
  localparam logic [1:0] SGN_O = 2'd1;
  localparam logic [1:0] SGN_P = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [2:0] LAST_PAIR = 3'd5;

  typedef struct packed {
    logic       capture;
    logic       load_ray;
    logic       div_start;
    logic       slope_load;
    logic       mul_load;
    logic       mul_org;
    logic       icpt_load;
    logic       chk;
    logic       out_load;
    logic [2:0] pair;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  // Axis pairs (a,b): (x,y) (x,z) (y,x) (y,z) (z,x) (z,y).
  function automatic logic [1:0] pair_a(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0, 3'd1: r = 2'd0;
      3'd2, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0:       r = 2'd1;
      3'd1, 3'd3: r = 2'd2;
      3'd2, 3'd4: r = 2'd0;
      default:    r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

>>> src/ray_box_slope_test_top.sv
// Top level of the ray versus axis-aligned box slope test.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------
//   in      | request   | in_valid, in_ready, in_op, in_first_*, in_second_*
//   out     | result    | out_valid, out_ready, out_hit
//
// A ray load runs the bit-serial slope divider once per axis pair.
// A box test uses one shared multiplier and one sum check per axis pair.
// One request is in work at a time; the hit bit sits in an output register, so a
// new request is taken while it waits, and only the next hit stalls on out_ready.
// Reset (synchronous, rst_n low) clears the stored ray to the all-minus class.
module ray_box_slope_test_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic signed [COORD_WIDTH-1:0] in_first_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_y,
  input  logic signed [COORD_WIDTH-1:0] in_first_z,
  input  logic signed [COORD_WIDTH-1:0] in_second_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit
);

  rbst_pkg::cmd_t    cmd;
  rbst_pkg::status_t status;

  rbst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rbst_dp #(
    .CW(COORD_WIDTH),
    .FB(FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .status  (status),
    .first_x (in_first_x),
    .first_y (in_first_y),
    .first_z (in_first_z),
    .second_x(in_second_x),
    .second_y(in_second_y),
    .second_z(in_second_z),
    .hit     (out_hit)
  );

endmodule

>>> src/rbst_div.sv
// Serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
`include "assert_macros.svh"

module rbst_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]   num_r, num_nxt;
  logic [NW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   den_r, den_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_diff;
  logic            qbit;

  always_comb begin
    rem_sh   = {rem_r, num_r[NW-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    qbit     = (rem_sh >= {1'b0, den_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(NW);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      quo_nxt = {quo_r[NW-2:0], qbit};
      rem_nxt = qbit ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

  `RBST_ASSERT_SAME(a_start_when_free, start, !busy_r)
  `RBST_ASSERT_NEXT(a_done_after_last, busy_r && cnt_r == CNTW'(1), done_r && !busy_r)

endmodule

>>> src/rbst_ctrl.sv
// Controller state machine that sequences ray loads and box tests.
`include "assert_macros.svh"

module rbst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rbst_pkg::status_t status,
  output rbst_pkg::cmd_t    cmd
);

  rbst_pkg::state_t state_r, state_nxt;
  logic [2:0]       pair_r, pair_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pair_nxt      = pair_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.pair      = pair_r;
    case (state_r)
      rbst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture  = 1'b1;
          cmd.load_ray = (in_op == rbst_pkg::OP_LOAD);
          pair_nxt     = 3'd0;
          state_nxt    = (in_op == rbst_pkg::OP_LOAD) ? rbst_pkg::ST_DIV_GO
                                                      : rbst_pkg::ST_TS_MUL;
        end
      end
      rbst_pkg::ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = rbst_pkg::ST_DIV_WAIT;
      end
      rbst_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.slope_load = 1'b1;
          state_nxt      = rbst_pkg::ST_LD_MUL;
        end
      end
      rbst_pkg::ST_LD_MUL: begin
        cmd.mul_load = 1'b1;
        cmd.mul_org  = 1'b1;
        state_nxt    = rbst_pkg::ST_LD_SUB;
      end
      rbst_pkg::ST_LD_SUB: begin
        cmd.icpt_load = 1'b1;
        if (pair_r == rbst_pkg::LAST_PAIR) begin
          pair_nxt  = 3'd0;
          state_nxt = rbst_pkg::ST_IDLE;
        end else begin
          pair_nxt  = pair_r + 3'd1;
          state_nxt = rbst_pkg::ST_DIV_GO;
        end
      end
      rbst_pkg::ST_TS_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = rbst_pkg::ST_TS_CHK;
      end
      rbst_pkg::ST_TS_CHK: begin
        cmd.chk = 1'b1;
        if (pair_r == rbst_pkg::LAST_PAIR) begin
          pair_nxt  = 3'd0;
          state_nxt = rbst_pkg::ST_DONE;
        end else begin
          pair_nxt  = pair_r + 3'd1;
          state_nxt = rbst_pkg::ST_TS_MUL;
        end
      end
      rbst_pkg::ST_DONE: begin
        // The result register must be free before a new hit bit lands in it.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rbst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rbst_pkg::ST_IDLE;
        pair_nxt  = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbst_pkg::ST_IDLE;
      pair_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pair_r      <= pair_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RBST_ASSERT_SAME(a_pair_range, 1'b1, pair_r <= rbst_pkg::LAST_PAIR)
  `RBST_ASSERT_SAME(a_accept_at_pair0, in_valid && in_ready, pair_r == 3'd0)

endmodule

>>> src/rbst_dp.sv
// Datapath with ray state, shared slope divider, shared multiplier and hit logic.
module rbst_dp #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rbst_pkg::cmd_t       cmd,
  output rbst_pkg::status_t    status,
  input  logic signed [CW-1:0] first_x,
  input  logic signed [CW-1:0] first_y,
  input  logic signed [CW-1:0] first_z,
  input  logic signed [CW-1:0] second_x,
  input  logic signed [CW-1:0] second_y,
  input  logic signed [CW-1:0] second_z,
  output logic                 hit
);

  localparam int NW = CW + FB;
  localparam int PW = 2 * CW;
  localparam int IW = ((PW > NW) ? PW : NW) + 1;
  localparam int SW = IW + 2;

  localparam logic [NW-1:0] LIM  = {{FB{1'b0}}, 1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] fst_r [3];
  logic signed [CW-1:0] snd_r [3];
  logic signed [CW-1:0] org_r [3];
  logic [1:0]           sgn_r [3];
  logic [1:0]           sgn_nxt [3];
  logic signed [CW-1:0] slope_r [6];
  logic signed [IW-1:0] icpt_r [6];
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic                 fail_r, fail_nxt;
  logic                 hit_r;

  logic [1:0]           pa, pb, sa, sb;
  logic [CW-1:0]        num_mag, den_mag;
  logic                 neg;
  logic                 div_done;
  logic [NW-1:0]        quo;
  logic signed [CW-1:0] slope_val;
  logic signed [CW-1:0] sel_a, sel_b, mul_b;
  logic signed [IW-1:0] ob_ext, selb_ext, icpt_nxt;
  logic signed [SW-1:0] sum;
  logic                 sg_pos, sg_neg, used, bnd_fail;
  logic signed [CW-1:0] in_fst [3];
  logic signed [CW-1:0] in_snd [3];

  assign in_fst[0] = first_x;
  assign in_fst[1] = first_y;
  assign in_fst[2] = first_z;
  assign in_snd[0] = second_x;
  assign in_snd[1] = second_y;
  assign in_snd[2] = second_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_snd[i][CW-1]) begin
        sgn_nxt[i] = rbst_pkg::SGN_M;
      end else if (in_snd[i] == '0) begin
        sgn_nxt[i] = rbst_pkg::SGN_O;
      end else begin
        sgn_nxt[i] = rbst_pkg::SGN_P;
      end
    end
    // An all-zero direction is handled as the class zero, zero, plus.
    if (in_snd[0] == '0 && in_snd[1] == '0 && in_snd[2] == '0) begin
      sgn_nxt[2] = rbst_pkg::SGN_P;
    end
  end

  assign pa = rbst_pkg::pair_a(cmd.pair);
  assign pb = rbst_pkg::pair_b(cmd.pair);
  assign sa = sgn_r[pa];
  assign sb = sgn_r[pb];

  assign num_mag = snd_r[pb][CW-1] ? CW'(-snd_r[pb]) : CW'(snd_r[pb]);
  assign den_mag = snd_r[pa][CW-1] ? CW'(-snd_r[pa]) : CW'(snd_r[pa]);
  assign neg     = snd_r[pb][CW-1] ^ snd_r[pa][CW-1];

  rbst_div #(
    .NW(NW),
    .DW(CW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  ({num_mag, {FB{1'b0}}}),
    .den  (den_mag),
    .done (div_done),
    .quo  (quo)
  );

  assign status.div_done = div_done;

  always_comb begin
    if (snd_r[pa] == '0) begin
      if (snd_r[pb][CW-1]) begin
        slope_val = MINV;
      end else if (snd_r[pb] == '0) begin
        slope_val = '0;
      end else begin
        slope_val = MAXV;
      end
    end else if (neg) begin
      slope_val = (quo >= LIM) ? MINV : CW'(-quo);
    end else begin
      slope_val = (quo >= LIM) ? MAXV : quo[CW-1:0];
    end
  end

  assign sel_a    = (sa == rbst_pkg::SGN_M) ? fst_r[pa] : snd_r[pa];
  assign sel_b    = (sb == rbst_pkg::SGN_M) ? snd_r[pb] : fst_r[pb];
  assign mul_b    = cmd.mul_org ? org_r[pa] : sel_a;
  assign prod_nxt = slope_r[cmd.pair] * mul_b;

  assign ob_ext   = IW'(org_r[pb]);
  assign selb_ext = IW'(sel_b);
  assign icpt_nxt = (ob_ext <<< FB) - IW'(prod_r);

  assign sum    = SW'(prod_r) + SW'(icpt_r[cmd.pair]) - SW'(selb_ext <<< FB);
  assign sg_neg = sum[SW-1];
  assign sg_pos = !sum[SW-1] && (sum != '0);
  assign used   = (sa != rbst_pkg::SGN_O) && (sb != rbst_pkg::SGN_O);

  always_comb begin
    fail_nxt = fail_r;
    if (cmd.capture) begin
      fail_nxt = 1'b0;
    end else if (cmd.chk && used) begin
      if ((sb == rbst_pkg::SGN_M && sg_pos) || (sb == rbst_pkg::SGN_P && sg_neg)) begin
        fail_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    bnd_fail = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (sgn_r[i] != rbst_pkg::SGN_P && org_r[i] < fst_r[i]) begin
        bnd_fail = 1'b1;
      end
      if (sgn_r[i] != rbst_pkg::SGN_M && org_r[i] > snd_r[i]) begin
        bnd_fail = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        sgn_r[i] <= rbst_pkg::SGN_M;
      end
      for (int i = 0; i < 6; i++) begin
        slope_r[i] <= '0;
        icpt_r[i]  <= '0;
      end
    end else begin
      if (cmd.capture && cmd.load_ray) begin
        for (int i = 0; i < 3; i++) begin
          org_r[i] <= in_fst[i];
          sgn_r[i] <= sgn_nxt[i];
        end
      end
      if (cmd.slope_load) begin
        slope_r[cmd.pair] <= slope_val;
      end
      if (cmd.icpt_load) begin
        icpt_r[cmd.pair] <= icpt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < 3; i++) begin
        fst_r[i] <= in_fst[i];
        snd_r[i] <= in_snd[i];
      end
    end
    if (cmd.mul_load) begin
      prod_r <= prod_nxt;
    end
    fail_r <= fail_nxt;
    if (cmd.out_load) begin
      hit_r <= !(fail_r || bnd_fail);
    end
  end

  assign hit = hit_r;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the ray versus axis-aligned box slope test.
module tb_top;

  typedef logic signed [31:0] crd_t;
  typedef logic signed [127:0] wide_t;

  localparam int  N_RANDOM   = 1400;
  localparam int  LOAD_WAIT  = 400;
  localparam int  STALL_LIM  = 5000;
  localparam int  HOLD_OFF   = 300;
  localparam logic [4:0] CLS_DEGEN = 5'd13;
  localparam logic [4:0] CLS_OOP   = 5'd14;
  localparam int  EXP_PREDICT = -1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = rbst_pkg::OP_LOAD;
  crd_t in_first_x = '0, in_first_y = '0, in_first_z = '0;
  crd_t in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;

  always #6 clk = ~clk;

  ray_box_slope_test_top dut (.*);

  // Predictor state: the ray the block should hold.
  logic [4:0] ray_cls;
  longint     ray_org[3];
  longint     slope_tab[6];
  longint     icpt_tab[6];
  int         pair_a_ax[6] = '{0, 0, 1, 1, 2, 2};
  int         pair_b_ax[6] = '{1, 2, 0, 2, 0, 1};

  bit   hit_queue[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_req = 1'b0;
  int   quiet_cycles = 0;

  function automatic logic [1:0] axis_cls(longint d);
    return d < 0 ? rbst_pkg::SGN_M : (d == 0 ? rbst_pkg::SGN_O : rbst_pkg::SGN_P);
  endfunction

  function automatic longint slope_div(longint num, longint den);
    longint q;
    if (den == 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic void store_ray(crd_t o[3], crd_t d[3]);
    logic [4:0] c;
    c = 5'(9 * axis_cls(d[0]) + 3 * axis_cls(d[1]) + axis_cls(d[2]));
    ray_cls = (c == CLS_DEGEN) ? CLS_OOP : c;
    for (int i = 0; i < 3; i++) ray_org[i] = o[i];
    for (int p = 0; p < 6; p++) begin
      slope_tab[p] = slope_div(longint'(d[pair_b_ax[p]]), longint'(d[pair_a_ax[p]]));
      icpt_tab[p]  = longint'(o[pair_b_ax[p]]) * 65536 - slope_tab[p] * longint'(o[pair_a_ax[p]]);
    end
  endfunction

  function automatic bit box_hits(crd_t lo[3], crd_t hi[3]);
    int    s[3];
    int    a, b;
    longint sa, sb;
    wide_t acc;
    if (ray_cls > 5'd26 || ray_cls == CLS_DEGEN) return 1'b0;
    s[0] = ray_cls / 9;
    s[1] = (ray_cls / 3) % 3;
    s[2] = ray_cls % 3;
    for (int i = 0; i < 3; i++) begin
      if (s[i] != rbst_pkg::SGN_P && ray_org[i] < longint'(lo[i])) return 1'b0;
      if (s[i] != rbst_pkg::SGN_M && ray_org[i] > longint'(hi[i])) return 1'b0;
    end
    for (int p = 0; p < 6; p++) begin
      a = pair_a_ax[p];
      b = pair_b_ax[p];
      if (s[a] == rbst_pkg::SGN_O || s[b] == rbst_pkg::SGN_O) continue;
      sa = (s[a] == rbst_pkg::SGN_M) ? lo[a] : hi[a];
      sb = (s[b] == rbst_pkg::SGN_M) ? hi[b] : lo[b];
      acc = wide_t'(slope_tab[p]) * wide_t'(sa) + wide_t'(icpt_tab[p]) - wide_t'(sb) * 65536;
      if (s[b] == rbst_pkg::SGN_M && acc > 0) return 1'b0;
      if (s[b] == rbst_pkg::SGN_P && acc < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Offers one request, waits for it to be taken, then updates the expectations.
  task automatic send(logic op, crd_t f[3], crd_t s[3], int typed_hit);
    bit h;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_first_x <= f[0]; in_first_y <= f[1]; in_first_z <= f[2];
    in_second_x <= s[0]; in_second_y <= s[1]; in_second_z <= s[2];
    do @(posedge clk); while (!in_ready);
    if (op == rbst_pkg::OP_LOAD) store_ray(f, s);
    else begin
      h = box_hits(f, s);
      hit_queue.push_back(typed_hit == EXP_PREDICT ? h : bit'(typed_hit));
    end
  endtask

  function automatic crd_t rand_coord(int spread);
    case ($urandom_range(9))
      0: return crd_t'($urandom);
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return crd_t'(int'($urandom_range(2 * spread)) - spread);
    endcase
  endfunction

  function automatic crd_t rand_dir_axis();
    int m;
    m = ($urandom_range(7) == 0) ? int'($urandom_range(32'h7fffffff, 1))
                                 : int'($urandom_range(1 << 20, 1));
    case ($urandom_range(2))
      0: return crd_t'(-m);
      1: return '0;
      default: return crd_t'(m);
    endcase
  endfunction

  typedef struct {
    logic op;
    crd_t f[3];
    crd_t s[3];
    int   hit;
  } row_t;

  row_t rows[$];

  function automatic void add_row(logic op, crd_t f0, crd_t f1, crd_t f2,
                                  crd_t s0, crd_t s1, crd_t s2, int hit);
    row_t r;
    r.op = op;
    r.f = '{f0, f1, f2};
    r.s = '{s0, s1, s2};
    r.hit = hit;
    rows.push_back(r);
  endfunction

  // Stimulus.
  initial begin
    crd_t f[3], s[3];
    crd_t cur_org[3];
    int   ext;
    store_ray('{0, 0, 0}, '{-1, -1, -1});
    ray_org = '{0, 0, 0};
    slope_tab = '{0, 0, 0, 0, 0, 0};
    icpt_tab = '{0, 0, 0, 0, 0, 0};
    ray_cls = '0;

    // Ray at reset: all-minus class, origin zero.
    add_row(rbst_pkg::OP_TEST, -1, -1, -1, 1, 1, 1, 1);
    add_row(rbst_pkg::OP_TEST, 32'sh10000, 0, 0, 2, 2, 2, 0);
    // All-zero direction behaves as the O-O-P class.
    add_row(rbst_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, EXP_PREDICT);
    add_row(rbst_pkg::OP_TEST, -1, -1, 5, 1, 1, 9, 1);
    add_row(rbst_pkg::OP_TEST, 0, 0, -9, 1, 1, -5, 0);
    // Extreme directions and boxes.
    add_row(rbst_pkg::OP_LOAD, 32'sh10000, -32'sh20000, 0, 32'sh7fffffff, 32'sh80000000,
            32'sh10000, EXP_PREDICT);
    add_row(rbst_pkg::OP_TEST, 32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, EXP_PREDICT);
    add_row(rbst_pkg::OP_TEST, 5, 5, 5, -5, -5, -5, EXP_PREDICT);
    // One zero axis, so some divisors are zero.
    add_row(rbst_pkg::OP_LOAD, 0, 32'sh8000, -32'sh8000, 0, 32'sh30000, -32'sh10000,
            EXP_PREDICT);
    add_row(rbst_pkg::OP_TEST, -32'sh10000, 0, -32'sh40000, 32'sh10000, 32'sh40000, 0,
            EXP_PREDICT);
    add_row(rbst_pkg::OP_TEST, 32'sh10000, 0, -32'sh40000, 32'sh20000, 32'sh40000, 0, 0);
    // Two zero axes: bounds only.
    add_row(rbst_pkg::OP_LOAD, 0, 0, 0, 32'sh10000, 0, 0, EXP_PREDICT);
    add_row(rbst_pkg::OP_TEST, 32'sh50000, -1, -1, 32'sh60000, 1, 1, 1);
    add_row(rbst_pkg::OP_TEST, 32'sh50000, 1, -1, 32'sh60000, 2, 1, 0);
    // Tiny and saturating slopes.
    add_row(rbst_pkg::OP_LOAD, 32'sh7fffffff, 32'sh80000000, 0, -32'sh10000, -1,
            -32'sh7fffffff, EXP_PREDICT);
    add_row(rbst_pkg::OP_TEST, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0,
            EXP_PREDICT);
    add_row(rbst_pkg::OP_LOAD, 0, 0, 0, 1, 32'sh7fffffff, 32'sh80000000, EXP_PREDICT);
    add_row(rbst_pkg::OP_TEST, 0, -32'sh100, -32'sh100, 32'sh100, 32'sh100, 32'sh100,
            EXP_PREDICT);
    add_row(rbst_pkg::OP_TEST, -32'sh7fffffff, -32'sh7fffffff, -32'sh7fffffff,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, EXP_PREDICT);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].op, rows[i].f, rows[i].s, rows[i].hit);

    cur_org = '{0, 0, 0};
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k < N_RANDOM / 3) begin
        send_idle_pct = 23; recv_idle_pct = 49;
      end else if (k < 2 * N_RANDOM / 3) begin
        send_idle_pct = 49; recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (k == 2 * N_RANDOM / 3) hold_req = 1'b1;
      if ($urandom_range(99) < 6) begin
        for (int i = 0; i < 3; i++) begin
          cur_org[i] = rand_coord(1 << 22);
          f[i] = cur_org[i];
          s[i] = rand_dir_axis();
        end
        send(rbst_pkg::OP_LOAD, f, s, EXP_PREDICT);
      end else begin
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(9) == 0) begin
            f[i] = rand_coord(1 << 24);
            s[i] = rand_coord(1 << 24);
          end else begin
            // Box near the origin, so that both outcomes are common.
            ext = $urandom_range(1 << 22);
            f[i] = crd_t'(longint'(cur_org[i]) - ext + int'($urandom_range(1 << 21)));
            s[i] = crd_t'(longint'(f[i]) + $urandom_range(1 << 23) - (1 << 18));
          end
        end
        send(rbst_pkg::OP_TEST, f, s, EXP_PREDICT);
      end
    end
    in_valid <= 1'b0;

    while (hit_queue.size() != 0) @(posedge clk);
    repeat (LOAD_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side flow control, with one long hold-off to fill the block.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checking.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit=%0b", $time, out_hit);
        errors++;
      end else begin
        if (out_hit !== hit_queue[0]) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, hit_queue[0],
                   out_hit);
          errors++;
        end
        void'(hit_queue.pop_front());
      end
    end
  end

  // Watchdog on cycles with no request or result taken.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIM) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

>>> files.f
+incdir+src
src/rbst_pkg.sv
src/rbst_div.sv
src/rbst_ctrl.sv
src/rbst_dp.sv
src/ray_box_slope_test_top.sv
tb/tb_top.sv
